// File: hw/rtl/stl_pkg.sv
package stl_pkg;

    localparam int CNT_W      = 16;
    localparam int KW_MAX_LEN = 6;
    localparam int KW_NUM     = 14;
    localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] LIMIT_DEFAULT = CNT_W'(1000);

    // token kinds
    localparam logic [5:0] KIND_IDENT   = 6'd0;
    localparam logic [5:0] KIND_INT     = 6'd15;
    localparam logic [5:0] KIND_FLOAT   = 6'd16;
    localparam logic [5:0] KIND_STRING  = 6'd17;
    localparam logic [5:0] KIND_LPAREN  = 6'd18;
    localparam logic [5:0] KIND_RPAREN  = 6'd19;
    localparam logic [5:0] KIND_LBRACE  = 6'd20;
    localparam logic [5:0] KIND_RBRACE  = 6'd21;
    localparam logic [5:0] KIND_SEMI    = 6'd22;
    localparam logic [5:0] KIND_STAR    = 6'd23;
    localparam logic [5:0] KIND_PERCENT = 6'd24;
    localparam logic [5:0] KIND_COLON   = 6'd25;
    localparam logic [5:0] KIND_OP_ONE  = 6'd26;
    localparam logic [5:0] KIND_OP_TWO  = 6'd27;
    localparam logic [5:0] KIND_SLASH   = 6'd32;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NUMBER  = 3'd1;
    localparam logic [2:0] ERR_STRING  = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN = 3'd3;
    localparam logic [2:0] ERR_MANY    = 3'd4;
    localparam logic [2:0] ERR_LONG    = 3'd5;

    // pending operator codes
    localparam logic [1:0] POP_EQ    = 2'd0;
    localparam logic [1:0] POP_PLUS  = 2'd1;
    localparam logic [1:0] POP_MINUS = 2'd2;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC,
        M_STRING, M_SLASH, M_COMMENT, M_DOUBLE, M_HALT
    } mode_t;

    typedef enum logic [1:0] {
        REQ_NONE, REQ_TOK, REQ_FAIL
    } req_t;

    typedef struct packed {
        logic [5:0]       kind;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] line;
        logic [CNT_W-1:0] col;
        logic [2:0]       err;
        logic             last;
    } res_t;

    // results of one input beat, from front to queue
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

    // keyword text, first character in the low byte
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_NUM] = '{
        (8*KW_MAX_LEN)'("fi"),    (8*KW_MAX_LEN)'("ro"),    (8*KW_MAX_LEN)'("nf"),
        (8*KW_MAX_LEN)'("dna"),   (8*KW_MAX_LEN)'("rof"),   (8*KW_MAX_LEN)'("tni"),
        (8*KW_MAX_LEN)'("ton"),   (8*KW_MAX_LEN)'("loob"),  (8*KW_MAX_LEN)'("esle"),
        (8*KW_MAX_LEN)'("txen"),  (8*KW_MAX_LEN)'("kaerb"), (8*KW_MAX_LEN)'("taolf"),
        (8*KW_MAX_LEN)'("elihw"), (8*KW_MAX_LEN)'("gnirts")
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6
    };

    function automatic logic [5:0] ident_kind(input logic [8*KW_MAX_LEN-1:0] kw,
                                              input logic [CNT_W-1:0] run);
        logic [5:0] k;
        logic       hit;
        k = KIND_IDENT;
        for (int i = 0; i < KW_NUM; i++) begin
            hit = (run == CNT_W'(KW_LEN[i]));
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < int'(KW_LEN[i]) && kw[8*j +: 8] != KW_TEXT[i][8*j +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                k = 6'(i + 1);
            end
        end
        return k;
    endfunction

    function automatic res_t mk_res(input logic [5:0] kind, input logic [CNT_W-1:0] len,
                                    input logic [CNT_W-1:0] line,
                                    input logic [CNT_W-1:0] col, input logic [2:0] err);
        res_t r;
        r.kind = kind;
        r.len  = len;
        r.line = line;
        r.col  = col;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

// File: hw/rtl/stl_if.sv
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface stl_out_if;
    logic                      valid;
    logic                      ready;
    logic [5:0]                token_kind;
    logic [stl_pkg::CNT_W-1:0] token_length;
    logic [stl_pkg::CNT_W-1:0] start_line;
    logic [stl_pkg::CNT_W-1:0] start_column;
    logic [2:0]                error_code;
    logic                      last_result;

    modport source (output valid, output token_kind, output token_length,
                    output start_line, output start_column, output error_code,
                    output last_result, input ready);
    modport sink (input valid, input token_kind, input token_length,
                  input start_line, input start_column, input error_code,
                  input last_result, output ready);
endinterface

// File: hw/rtl/stl_front.sv
module stl_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             char_code,
    input  logic                   end_of_input,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_data,
    output stl_pkg::push_t         push
);

    stl_pkg::mode_t                     mode_reg, mode_next;
    logic [1:0]                         pend_reg, pend_next;
    logic [7:0]                         kw_reg [stl_pkg::KW_MAX_LEN];
    logic [stl_pkg::CNT_W-1:0]          run_reg, run_next;
    logic [stl_pkg::CNT_W-1:0]          tline_reg, tline_next;
    logic [stl_pkg::CNT_W-1:0]          tcol_reg, tcol_next;
    logic [stl_pkg::CNT_W-1:0]          cline_reg, cline_next;
    logic [stl_pkg::CNT_W-1:0]          ccol_reg, ccol_next;
    logic [stl_pkg::CNT_W-1:0]          emit_reg, emit_next;
    logic [stl_pkg::CNT_W-1:0]          limit_reg;
    logic                               kw_we;
    logic [stl_pkg::KW_IDX_W-1:0]       kw_idx;
    logic [8*stl_pkg::KW_MAX_LEN-1:0]   kw_flat;

    // character classes
    logic is_alpha, is_digit, is_ident, is_ws, is_nl;
    logic [5:0] single_kind;
    logic       is_single;

    function automatic logic [stl_pkg::CNT_W-1:0] CNT_ONE();
        return stl_pkg::CNT_W'(1);
    endfunction

    function automatic logic [stl_pkg::CNT_W-1:0] CNT_W_TWO();
        return stl_pkg::CNT_W'(2);
    endfunction

    always_comb
    begin
        for (int i = 0; i < stl_pkg::KW_MAX_LEN; i++) begin
            kw_flat[8*i +: 8] = kw_reg[i];
        end
    end

    assign is_alpha = (char_code >= "a" && char_code <= "z") ||
                      (char_code >= "A" && char_code <= "Z");
    assign is_digit = (char_code >= "0" && char_code <= "9");
    assign is_ident = is_alpha || is_digit || char_code == "_";
    assign is_nl    = (char_code == 8'h0A);
    assign is_ws    = (char_code == " ") || (char_code == 8'h09) || is_nl;

    always_comb
    begin
        is_single   = 1'b1;
        single_kind = stl_pkg::KIND_IDENT;
        unique case (char_code)
            "(":     single_kind = stl_pkg::KIND_LPAREN;
            ")":     single_kind = stl_pkg::KIND_RPAREN;
            "{":     single_kind = stl_pkg::KIND_LBRACE;
            "}":     single_kind = stl_pkg::KIND_RBRACE;
            ";":     single_kind = stl_pkg::KIND_SEMI;
            "*":     single_kind = stl_pkg::KIND_STAR;
            "%":     single_kind = stl_pkg::KIND_PERCENT;
            ":":     single_kind = stl_pkg::KIND_COLON;
            default: is_single = 1'b0;
        endcase
    end

    // lexer step for one beat: continue the current token, then maybe start one
    always_comb
    begin
        logic [stl_pkg::CNT_W-1:0] cl, cc;
        logic [1:0]                p;
        logic [7:0]                opc;
        logic                      do_start;
        stl_pkg::req_t             rq;
        logic [5:0]                rkind;
        logic [stl_pkg::CNT_W-1:0] rlen, rline, rcol;
        logic [2:0]                rerr;
        stl_pkg::res_t             x;
        logic [1:0]                n;
        stl_pkg::res_t             r0, r1;

        mode_next  = mode_reg;
        pend_next  = pend_reg;
        run_next   = run_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        cline_next = cline_reg;
        ccol_next  = ccol_reg;
        emit_next  = emit_reg;
        kw_we      = 1'b0;
        kw_idx     = '0;
        n          = 2'd0;
        r0         = '0;
        r1         = '0;
        x          = '0;
        do_start   = 1'b0;
        rq         = stl_pkg::REQ_NONE;
        rkind      = stl_pkg::KIND_IDENT;
        rlen       = '0;
        rline      = tline_reg;
        rcol       = tcol_reg;
        rerr       = stl_pkg::ERR_NONE;
        p          = (pend_reg == 2'd3) ? stl_pkg::POP_EQ : pend_reg;
        unique case (p)
            stl_pkg::POP_PLUS:  opc = "+";
            stl_pkg::POP_MINUS: opc = "-";
            default:            opc = "=";
        endcase
        cl = cline_reg;
        cc = (ccol_reg == stl_pkg::CNT_MAX) ? stl_pkg::CNT_MAX : ccol_reg + 1'b1;

        if (accept && mode_reg != stl_pkg::M_HALT) begin
            if (end_of_input) begin
                // flush the pending token
                unique case (mode_reg)
                    stl_pkg::M_IDENT:  begin rq = stl_pkg::REQ_TOK;
                        rkind = stl_pkg::ident_kind(kw_flat, run_reg); rlen = run_reg; end
                    stl_pkg::M_INT:    begin rq = stl_pkg::REQ_TOK;
                        rkind = stl_pkg::KIND_INT; rlen = run_reg; end
                    stl_pkg::M_DOT:    begin rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_NUMBER; end
                    stl_pkg::M_FRAC:   begin rq = stl_pkg::REQ_TOK;
                        rkind = stl_pkg::KIND_FLOAT; rlen = run_reg; end
                    stl_pkg::M_STRING: begin rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_STRING; end
                    stl_pkg::M_SLASH:  begin rq = stl_pkg::REQ_TOK;
                        rkind = stl_pkg::KIND_SLASH; rlen = CNT_ONE(); end
                    stl_pkg::M_DOUBLE: begin rq = stl_pkg::REQ_TOK;
                        rkind = stl_pkg::KIND_OP_ONE + {3'd0, p, 1'b0}; rlen = CNT_ONE(); end
                    default:           mode_next = stl_pkg::M_IDLE;
                endcase
            end else begin
                // advance the source position
                if (is_nl) begin
                    if (cline_reg != stl_pkg::CNT_MAX) begin
                        cline_next = cline_reg + 1'b1;
                    end
                    ccol_next = '0;
                end else begin
                    ccol_next = cc;
                end

                unique case (mode_reg)
                    stl_pkg::M_IDENT:
                    begin
                        if (is_ident) begin
                            if (run_reg == stl_pkg::CNT_MAX) begin
                                rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_LONG;
                            end else begin
                                run_next = run_reg + 1'b1;
                                if (run_reg < stl_pkg::CNT_W'(stl_pkg::KW_MAX_LEN)) begin
                                    kw_we  = 1'b1;
                                    kw_idx = run_reg[stl_pkg::KW_IDX_W-1:0];
                                end
                            end
                        end else begin
                            rq = stl_pkg::REQ_TOK; do_start = 1'b1;
                            rkind = stl_pkg::ident_kind(kw_flat, run_reg); rlen = run_reg;
                        end
                    end
                    stl_pkg::M_INT, stl_pkg::M_FRAC:
                    begin
                        if (is_digit || (char_code == "." && mode_reg == stl_pkg::M_INT)) begin
                            if (run_reg == stl_pkg::CNT_MAX) begin
                                rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_LONG;
                            end else begin
                                run_next = run_reg + 1'b1;
                                if (!is_digit) begin
                                    mode_next = stl_pkg::M_DOT;
                                end
                            end
                        end else begin
                            rq = stl_pkg::REQ_TOK; do_start = 1'b1; rlen = run_reg;
                            rkind = (mode_reg == stl_pkg::M_INT) ? stl_pkg::KIND_INT
                                                                 : stl_pkg::KIND_FLOAT;
                        end
                    end
                    stl_pkg::M_DOT:
                    begin
                        if (!is_digit) begin
                            rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_NUMBER;
                        end else if (run_reg == stl_pkg::CNT_MAX) begin
                            rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_LONG;
                        end else begin
                            run_next  = run_reg + 1'b1;
                            mode_next = stl_pkg::M_FRAC;
                        end
                    end
                    stl_pkg::M_STRING:
                    begin
                        if (is_nl) begin
                            rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_STRING;
                        end else if (run_reg == stl_pkg::CNT_MAX) begin
                            rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_LONG;
                        end else if (char_code == "\"") begin
                            rq = stl_pkg::REQ_TOK; rkind = stl_pkg::KIND_STRING;
                            rlen = run_reg + 1'b1;
                        end else begin
                            run_next = run_reg + 1'b1;
                        end
                    end
                    stl_pkg::M_SLASH:
                    begin
                        if (char_code == "/") begin
                            mode_next = stl_pkg::M_COMMENT;
                        end else begin
                            rq = stl_pkg::REQ_TOK; do_start = 1'b1;
                            rkind = stl_pkg::KIND_SLASH; rlen = CNT_ONE();
                        end
                    end
                    stl_pkg::M_COMMENT:
                    begin
                        if (is_nl) begin
                            mode_next = stl_pkg::M_IDLE;
                        end
                    end
                    stl_pkg::M_DOUBLE:
                    begin
                        rq = stl_pkg::REQ_TOK;
                        if (char_code == opc) begin
                            rkind = stl_pkg::KIND_OP_TWO + {3'd0, p, 1'b0};
                            rlen  = CNT_W_TWO();
                        end else begin
                            rkind = stl_pkg::KIND_OP_ONE + {3'd0, p, 1'b0};
                            rlen  = CNT_ONE();
                            do_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = stl_pkg::M_IDLE;
                        do_start  = 1'b1;
                    end
                endcase
            end

            // resolve the first result
            unique case (rq)
                stl_pkg::REQ_TOK:
                begin
                    if (emit_next >= limit_reg) begin
                        x = stl_pkg::mk_res(stl_pkg::KIND_IDENT, '0, tline_next, tcol_next,
                                            stl_pkg::ERR_MANY);
                        mode_next = stl_pkg::M_HALT;
                    end else begin
                        emit_next = emit_next + 1'b1;
                        mode_next = stl_pkg::M_IDLE;
                        x = stl_pkg::mk_res(rkind, rlen, tline_next, tcol_next,
                                            stl_pkg::ERR_NONE);
                    end
                end
                stl_pkg::REQ_FAIL:
                begin
                    x = stl_pkg::mk_res(stl_pkg::KIND_IDENT, '0, rline, rcol, rerr);
                    mode_next = stl_pkg::M_HALT;
                end
                default: ;
            endcase
            if (rq != stl_pkg::REQ_NONE) begin
                r0 = x;
                n  = 2'd1;
            end

            // start a new token from this character
            rq = stl_pkg::REQ_NONE;
            if (do_start && mode_next != stl_pkg::M_HALT && !is_ws) begin
                if (is_single || char_code == "/" || char_code == "\"" || char_code == "=" ||
                    char_code == "+" || char_code == "-" || is_alpha ||
                    char_code == "_" || is_digit) begin
                    tline_next = cl;
                    tcol_next  = cc;
                    run_next   = CNT_ONE();
                end
                priority if (is_single) begin
                    mode_next = stl_pkg::M_IDLE;
                    rq = stl_pkg::REQ_TOK; rkind = single_kind; rlen = CNT_ONE();
                end else if (char_code == "/") begin
                    mode_next = stl_pkg::M_SLASH;
                end else if (char_code == "\"") begin
                    mode_next = stl_pkg::M_STRING;
                end else if (char_code == "=" || char_code == "+" || char_code == "-") begin
                    mode_next = stl_pkg::M_DOUBLE;
                    pend_next = (char_code == "=") ? stl_pkg::POP_EQ :
                                (char_code == "+") ? stl_pkg::POP_PLUS : stl_pkg::POP_MINUS;
                end else if (is_alpha || char_code == "_") begin
                    mode_next = stl_pkg::M_IDENT;
                    kw_we     = 1'b1;
                    kw_idx    = '0;
                end else if (is_digit) begin
                    mode_next = stl_pkg::M_INT;
                end else begin
                    rq = stl_pkg::REQ_FAIL; rerr = stl_pkg::ERR_UNKNOWN;
                    rline = cl; rcol = cc;
                end
            end

            // resolve the second result
            unique case (rq)
                stl_pkg::REQ_TOK:
                begin
                    if (emit_next >= limit_reg) begin
                        x = stl_pkg::mk_res(stl_pkg::KIND_IDENT, '0, tline_next, tcol_next,
                                            stl_pkg::ERR_MANY);
                        mode_next = stl_pkg::M_HALT;
                    end else begin
                        emit_next = emit_next + 1'b1;
                        mode_next = stl_pkg::M_IDLE;
                        x = stl_pkg::mk_res(rkind, rlen, tline_next, tcol_next,
                                            stl_pkg::ERR_NONE);
                    end
                end
                stl_pkg::REQ_FAIL:
                begin
                    x = stl_pkg::mk_res(stl_pkg::KIND_IDENT, '0, rline, rcol, rerr);
                    mode_next = stl_pkg::M_HALT;
                end
                default: ;
            endcase
            if (rq != stl_pkg::REQ_NONE) begin
                if (n == 2'd0) begin
                    r0 = x;
                end else begin
                    r1 = x;
                end
                n = n + 2'd1;
            end

            // end of input restarts the source position and count
            if (end_of_input && mode_next != stl_pkg::M_HALT) begin
                mode_next  = stl_pkg::M_IDLE;
                run_next   = '0;
                tline_next = CNT_ONE();
                tcol_next  = CNT_ONE();
                cline_next = CNT_ONE();
                ccol_next  = '0;
                emit_next  = '0;
            end

            if (n == 2'd1) begin
                r0.last = 1'b1;
            end else if (n == 2'd2) begin
                r1.last = 1'b1;
            end
        end

        push.cnt = n;
        push.r0  = r0;
        push.r1  = r1;
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= stl_pkg::M_IDLE;
            pend_reg  <= stl_pkg::POP_EQ;
            run_reg   <= '0;
            tline_reg <= stl_pkg::CNT_W'(1);
            tcol_reg  <= stl_pkg::CNT_W'(1);
            cline_reg <= stl_pkg::CNT_W'(1);
            ccol_reg  <= '0;
            emit_reg  <= '0;
            limit_reg <= stl_pkg::LIMIT_DEFAULT;
        end else begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            run_reg   <= run_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            cline_reg <= cline_next;
            ccol_reg  <= ccol_next;
            emit_reg  <= emit_next;
            if (cfg_we) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // keyword character store
    always_ff @(posedge clk)
    begin
        if (kw_we) begin
            kw_reg[kw_idx] <= char_code;
        end
    end

endmodule

// File: hw/rtl/stl_queue.sv
module stl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  stl_pkg::push_t push,
    output logic           space,
    output logic           head_valid,
    output stl_pkg::res_t  head,
    input  logic           pop
);

    stl_pkg::res_t                mem [stl_pkg::Q_DEPTH];
    logic [stl_pkg::Q_PTR_W-1:0]  wr_reg, wr_next;
    logic [stl_pkg::Q_PTR_W-1:0]  rd_reg, rd_next;
    logic [stl_pkg::Q_PTR_W:0]    cnt_reg, cnt_next;
    logic [stl_pkg::Q_PTR_W-1:0]  wr_plus;

    // room for the two results of one beat
    assign space      = (cnt_reg <= (stl_pkg::Q_PTR_W+1)'(stl_pkg::Q_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];
    assign wr_plus    = wr_reg + 1'b1;

    // pointer and fill count
    always_comb
    begin
        wr_next  = wr_reg + stl_pkg::Q_PTR_W'(push.cnt);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (stl_pkg::Q_PTR_W+1)'(push.cnt)
                   - (stl_pkg::Q_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0) begin
            mem[wr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_plus] <= push.r1;
        end
    end

endmodule

// File: hw/rtl/stl_back.sv
module stl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  stl_pkg::res_t  head,
    output logic           pop,
    stl_out_if.source      out_ch
);

    logic          valid_reg;
    stl_pkg::res_t data_reg;

    // refill the output register when it is empty or its beat is taken
    assign pop = head_valid && (!valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || out_ch.ready) begin
            valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            data_reg <= head;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.token_kind   = data_reg.kind;
    assign out_ch.token_length = data_reg.len;
    assign out_ch.start_line   = data_reg.line;
    assign out_ch.start_column = data_reg.col;
    assign out_ch.error_code   = data_reg.err;
    assign out_ch.last_result  = data_reg.last;

endmodule

// File: hw/rtl/source_token_lexer_top.sv
// path: a result is written into the queue, then into the output register, before it appears on the output
// throughput: one input beat per cycle while the queue has space; each beat gives zero, one or two results
// the output drains one result per cycle while out_ch.ready is high, so a run of two-result beats backs up the queue
// reset: asynchronous active low; lexer idle at line 1, token limit 1000, queue empty
// after an error the lexer keeps taking beats but gives no results until reset
module source_token_lexer_top (
    input  logic        clk,
    input  logic        rst_n,
    stl_in_if.sink      in_ch,
    stl_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    stl_pkg::push_t push;
    stl_pkg::res_t  head;
    logic           space;
    logic           head_valid;
    logic           pop;
    logic           accept;

    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    // front: classify characters and build results
    stl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_code    (in_ch.char_code),
        .end_of_input (in_ch.end_of_input),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .push         (push)
    );

    // result queue between front and back
    stl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (space),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // back: output register
    stl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
